FILE: hdl/sprite_quad_vertex_gen_macros.svh
// Assertion macros used by the checker file.
`ifndef SPRITE_QUAD_VERTEX_GEN_MACROS_SVH
`define SPRITE_QUAD_VERTEX_GEN_MACROS_SVH

// Checked at every clock edge, quiet while reset is high.
`define SQV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, including reset.
`define SQV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/sqv_pkg.sv
`default_nettype none
package sqv_pkg;

   localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_PIVOT_H       = 3'd2;
   localparam logic [2:0] REG_PIVOT_V       = 3'd3;
   localparam logic [2:0] REG_TEX_LEFT      = 3'd4;
   localparam logic [2:0] REG_TEX_TOP       = 3'd5;
   localparam logic [2:0] REG_TEX_RIGHT     = 3'd6;
   localparam logic [2:0] REG_TEX_BOTTOM    = 3'd7;

   localparam logic [1:0] CORNER_LAST = 2'd3;

   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [32:0] PI_Q30      = 33'sd3373259426;
   localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
   localparam logic signed [35:0] PI_W        = 36'sd3373259426;
   localparam logic signed [35:0] THREE_PI_W  = 36'sd10119778278;
   localparam logic signed [35:0] TWO_PI_W    = 36'sd6746518852;
   localparam logic signed [35:0] FOUR_PI_W   = 36'sd13493037704;

   // Everything that rides alongside the angle through the rotator.
   typedef struct packed {
      logic signed [33:0] ox0;
      logic signed [33:0] ox1;
      logic signed [33:0] oy0;
      logic signed [33:0] oy1;
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic [7:0]         mode;
      logic               neg;
      logic               zero;
   } side_type;

   function automatic logic signed [32:0] atan_q30(input logic [4:0] idx);
      logic signed [32:0] r;
      case (idx)
         5'd0:  r = 33'sh03243F6A8;
         5'd1:  r = 33'sh01DAC6705;
         5'd2:  r = 33'sh00FADBAFC;
         5'd3:  r = 33'sh007F56EA6;
         5'd4:  r = 33'sh003FEAB76;
         5'd5:  r = 33'sh001FFD55B;
         5'd6:  r = 33'sh000FFFAAA;
         5'd7:  r = 33'sh0007FFF55;
         5'd8:  r = 33'sh0003FFFEA;
         5'd9:  r = 33'sh0001FFFFD;
         5'd10: r = 33'sh0000FFFFF;
         5'd11: r = 33'sh00007FFFF;
         5'd12: r = 33'sh00003FFFF;
         5'd13: r = 33'sh00001FFFF;
         5'd14: r = 33'sh00000FFFF;
         5'd15: r = 33'sh000007FFF;
         5'd16: r = 33'sh000003FFF;
         5'd17: r = 33'sh000001FFF;
         5'd18: r = 33'sh000000FFF;
         5'd19: r = 33'sh0000007FF;
         5'd20: r = 33'sh0000003FF;
         5'd21: r = 33'sh0000001FF;
         5'd22: r = 33'sh0000000FF;
         5'd23: r = 33'sh00000007F;
         default: r = 33'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sprite_quad_vertex_gen.sv
`default_nettype none
// Sprite quad corner generator. Each request word (anchor, angle, scale, blend mode)
// yields four corner words, top-left, top-right, bottom-right, bottom-left, with tlast
// on the fourth. One corner leaves per cycle, and all stages hold while the result
// register waits on rsp_tready. A request is taken only when the serializer is empty
// or on its fourth corner. A request passes four setup stages, one rotator stage per
// CORDIC iteration, one sine/cosine rounding stage and three corner stages. The user
// must write registers through csr_* only while no request is in flight; not enforced.
module sprite_quad_vertex_gen #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // center_x[23:0], center_y[47:24], rotation[63:48], scale_x[79:64], scale_y[95:80]
   input  wire logic [95:0] req_tdata,
   // blend_mode[7:0]
   input  wire logic [7:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pos_x[31:0], pos_y[63:32], tex_u[79:64], tex_v[95:80]
   output logic [95:0]      rsp_tdata,
   // corner[1:0], mode_out[9:2]
   output logic [9:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   typedef struct packed {
      sqv_pkg::side_type  side;
      logic signed [15:0] c;
      logic signed [15:0] s;
   } quad_type;

   // registers
   logic [15:0] width_ff, height_ff, piv_h_ff, piv_v_ff;
   logic [15:0] tex_l_ff, tex_t_ff, tex_r_ff, tex_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 16'd1024;
         height_ff <= 16'd1024;
         piv_h_ff  <= 16'd16384;
         piv_v_ff  <= 16'd16384;
         tex_l_ff  <= 16'd0;
         tex_t_ff  <= 16'd0;
         tex_r_ff  <= 16'd32768;
         tex_b_ff  <= 16'd32768;
      end else if (csr_wen) begin
         case (csr_addr)
            sqv_pkg::REG_SPRITE_WIDTH:  width_ff  <= csr_wdata;
            sqv_pkg::REG_SPRITE_HEIGHT: height_ff <= csr_wdata;
            sqv_pkg::REG_PIVOT_H:       piv_h_ff  <= csr_wdata;
            sqv_pkg::REG_PIVOT_V:       piv_v_ff  <= csr_wdata;
            sqv_pkg::REG_TEX_LEFT:      tex_l_ff  <= csr_wdata;
            sqv_pkg::REG_TEX_TOP:       tex_t_ff  <= csr_wdata;
            sqv_pkg::REG_TEX_RIGHT:     tex_r_ff  <= csr_wdata;
            sqv_pkg::REG_TEX_BOTTOM:    tex_b_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // flow control
   logic adv, ser_take, rq_adv;
   logic ser_valid_ff;
   logic [1:0] ser_cnt_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign ser_take   = !ser_valid_ff || (ser_cnt_ff == sqv_pkg::CORNER_LAST);
   assign rq_adv     = adv && ser_take;
   assign req_tready = rq_adv;

   // stage a: input word
   logic a_valid_ff;
   logic signed [23:0] a_cx_ff, a_cy_ff;
   logic signed [15:0] a_rot_ff, a_sx_ff, a_sy_ff;
   logic [7:0] a_mode_ff;

   // stage b: size times pivot, whole-turn wrap
   logic b_valid_ff;
   logic [31:0] b_wph_ff, b_hpv_ff;
   logic signed [32:0] b_wpr_ff, b_hpr_ff, b_z_ff;
   logic signed [23:0] b_cx_ff, b_cy_ff;
   logic signed [15:0] b_sx_ff, b_sy_ff;
   logic [7:0] b_mode_ff;
   logic b_zero_ff;

   logic signed [17:0] pr_h, pr_v;
   logic signed [34:0] wpr_full, hpr_full;
   logic signed [35:0] z_full, z_in;

   always_comb begin
      pr_h     = 18'sd32768 - $signed({2'b00, piv_h_ff});
      pr_v     = 18'sd32768 - $signed({2'b00, piv_v_ff});
      wpr_full = 35'($signed({1'b0, width_ff}) * pr_h);
      hpr_full = 35'($signed({1'b0, height_ff}) * pr_v);
      z_full   = {{2{a_rot_ff[15]}}, a_rot_ff, 18'd0};
      if (z_full > sqv_pkg::THREE_PI_W) begin
         z_in = z_full - sqv_pkg::FOUR_PI_W;
      end else if (z_full > sqv_pkg::PI_W) begin
         z_in = z_full - sqv_pkg::TWO_PI_W;
      end else if (z_full < -sqv_pkg::THREE_PI_W) begin
         z_in = z_full + sqv_pkg::FOUR_PI_W;
      end else if (z_full < -sqv_pkg::PI_W) begin
         z_in = z_full + sqv_pkg::TWO_PI_W;
      end else begin
         z_in = z_full;
      end
   end

   // stage c: times scale, half-turn fold
   logic c_valid_ff;
   logic signed [48:0] c_pl_ff, c_pr_ff, c_pt_ff, c_pb_ff;
   logic signed [32:0] c_z_ff;
   logic signed [23:0] c_cx_ff, c_cy_ff;
   logic [7:0] c_mode_ff;
   logic c_zero_ff, c_neg_ff;
   logic signed [32:0] zc_in;
   logic neg_in;

   always_comb begin
      if (b_z_ff > sqv_pkg::HALF_PI_Q30) begin
         zc_in  = b_z_ff - sqv_pkg::PI_Q30;
         neg_in = 1'b1;
      end else if (b_z_ff < -sqv_pkg::HALF_PI_Q30) begin
         zc_in  = b_z_ff + sqv_pkg::PI_Q30;
         neg_in = 1'b1;
      end else begin
         zc_in  = b_z_ff;
         neg_in = 1'b0;
      end
   end

   // stage d: round offsets to Q.12
   logic d_valid_ff;
   logic signed [32:0] d_z_ff;
   sqv_pkg::side_type d_side_ff, d_side_in;
   logic signed [49:0] rl, rr, rt, rb;

   always_comb begin
      rl = ((-50'(c_pl_ff)) + 50'sd16384) >>> 15;
      rr = (50'(c_pr_ff) + 50'sd16384) >>> 15;
      rt = ((-50'(c_pt_ff)) + 50'sd16384) >>> 15;
      rb = (50'(c_pb_ff) + 50'sd16384) >>> 15;
      d_side_in.ox0  = rl[33:0];
      d_side_in.ox1  = rr[33:0];
      d_side_in.oy0  = rt[33:0];
      d_side_in.oy1  = rb[33:0];
      d_side_in.cx   = c_cx_ff;
      d_side_in.cy   = c_cy_ff;
      d_side_in.mode = c_mode_ff;
      d_side_in.neg  = c_neg_ff;
      d_side_in.zero = c_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (rq_adv) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_adv) begin
         a_cx_ff   <= $signed(req_tdata[23:0]);
         a_cy_ff   <= $signed(req_tdata[47:24]);
         a_rot_ff  <= $signed(req_tdata[63:48]);
         a_sx_ff   <= $signed(req_tdata[79:64]);
         a_sy_ff   <= $signed(req_tdata[95:80]);
         a_mode_ff <= req_tuser;

         b_wph_ff  <= 32'(width_ff) * 32'(piv_h_ff);
         b_hpv_ff  <= 32'(height_ff) * 32'(piv_v_ff);
         b_wpr_ff  <= wpr_full[32:0];
         b_hpr_ff  <= hpr_full[32:0];
         b_z_ff    <= z_in[32:0];
         b_cx_ff   <= a_cx_ff;
         b_cy_ff   <= a_cy_ff;
         b_sx_ff   <= a_sx_ff;
         b_sy_ff   <= a_sy_ff;
         b_mode_ff <= a_mode_ff;
         b_zero_ff <= (a_rot_ff == 16'sd0);

         c_pl_ff   <= 49'($signed({1'b0, b_wph_ff}) * b_sx_ff);
         c_pr_ff   <= 49'(b_wpr_ff * b_sx_ff);
         c_pt_ff   <= 49'($signed({1'b0, b_hpv_ff}) * b_sy_ff);
         c_pb_ff   <= 49'(b_hpr_ff * b_sy_ff);
         c_z_ff    <= zc_in;
         c_cx_ff   <= b_cx_ff;
         c_cy_ff   <= b_cy_ff;
         c_mode_ff <= b_mode_ff;
         c_zero_ff <= b_zero_ff;
         c_neg_ff  <= neg_in;

         d_z_ff    <= c_z_ff;
         d_side_ff <= d_side_in;
      end
   end

   // rotator
   logic cr_valid;
   logic signed [32:0] cr_x, cr_y;
   sqv_pkg::side_type cr_side;

   sqv_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (rq_adv),
      .in_valid  (d_valid_ff),
      .in_z      (d_z_ff),
      .in_side   (d_side_ff),
      .out_valid (cr_valid),
      .out_x     (cr_x),
      .out_y     (cr_y),
      .out_side  (cr_side)
   );

   // stage e: round to Q1.14, clamp, fold back the half turn
   logic e_valid_ff;
   quad_type e_ff, e_in;
   logic signed [33:0] xr, yr;
   logic signed [17:0] cq, sq;
   logic signed [15:0] cc, sc;

   always_comb begin
      xr = (34'(cr_x) + 34'sd32768) >>> 16;
      yr = (34'(cr_y) + 34'sd32768) >>> 16;
      cq = xr[17:0];
      sq = yr[17:0];
      if (xr > 34'sd16384) begin
         cc = 16'sd16384;
      end else if (xr < -34'sd16384) begin
         cc = -16'sd16384;
      end else begin
         cc = cq[15:0];
      end
      if (yr > 34'sd16384) begin
         sc = 16'sd16384;
      end else if (yr < -34'sd16384) begin
         sc = -16'sd16384;
      end else begin
         sc = sq[15:0];
      end
      e_in.side = cr_side;
      if (cr_side.zero) begin
         e_in.c = 16'sd16384;
         e_in.s = 16'sd0;
      end else if (cr_side.neg) begin
         e_in.c = -cc;
         e_in.s = -sc;
      end else begin
         e_in.c = cc;
         e_in.s = sc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (rq_adv) begin
         e_valid_ff <= cr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_adv) begin
         e_ff <= e_in;
      end
   end

   // corner serializer
   quad_type ser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_cnt_ff   <= 2'd0;
      end else if (adv) begin
         if (ser_take) begin
            ser_valid_ff <= e_valid_ff;
            ser_cnt_ff   <= 2'd0;
         end else begin
            ser_cnt_ff   <= ser_cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && ser_take) begin
         ser_ff <= e_ff;
      end
   end

   // corner stage 1: products
   logic k1_valid_ff;
   logic signed [49:0] k1_pxc_ff, k1_pys_ff, k1_pxs_ff, k1_pyc_ff;
   logic signed [23:0] k1_cx_ff, k1_cy_ff;
   logic [15:0] k1_u_ff, k1_v_ff;
   logic [7:0] k1_mode_ff;
   logic [1:0] k1_corner_ff;
   logic sel_x, sel_y;
   logic signed [33:0] ox_sel, oy_sel;

   always_comb begin
      sel_x  = ser_cnt_ff[0] ^ ser_cnt_ff[1];
      sel_y  = ser_cnt_ff[1];
      ox_sel = sel_x ? ser_ff.side.ox1 : ser_ff.side.ox0;
      oy_sel = sel_y ? ser_ff.side.oy1 : ser_ff.side.oy0;
   end

   // corner stage 2: combine, round to Q.8, add anchor
   logic k2_valid_ff;
   logic signed [34:0] k2_px_ff, k2_py_ff;
   logic [15:0] k2_u_ff, k2_v_ff;
   logic [7:0] k2_mode_ff;
   logic [1:0] k2_corner_ff;
   logic signed [50:0] rx, ry, rxr, ryr;

   always_comb begin
      rx  = 51'(k1_pxc_ff) - 51'(k1_pys_ff);
      ry  = 51'(k1_pxs_ff) + 51'(k1_pyc_ff);
      rxr = (rx + 51'sd131072) >>> 18;
      ryr = (ry + 51'sd131072) >>> 18;
   end

   // result register
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic [15:0] tex_u_ff, tex_v_ff;
   logic [7:0] mode_ff;
   logic [1:0] corner_ff;
   logic rsp_valid_ff;

   always_comb begin
      if (k2_px_ff > 35'sd2147483647) begin
         pos_x_in = 32'sh7fffffff;
      end else if (k2_px_ff < -35'sd2147483648) begin
         pos_x_in = 32'sh80000000;
      end else begin
         pos_x_in = k2_px_ff[31:0];
      end
      if (k2_py_ff > 35'sd2147483647) begin
         pos_y_in = 32'sh7fffffff;
      end else if (k2_py_ff < -35'sd2147483648) begin
         pos_y_in = 32'sh80000000;
      end else begin
         pos_y_in = k2_py_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_valid_ff  <= 1'b0;
         k2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         k1_valid_ff  <= ser_valid_ff;
         k2_valid_ff  <= k1_valid_ff;
         rsp_valid_ff <= k2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_pxc_ff    <= 50'(ox_sel * ser_ff.c);
         k1_pys_ff    <= 50'(oy_sel * ser_ff.s);
         k1_pxs_ff    <= 50'(ox_sel * ser_ff.s);
         k1_pyc_ff    <= 50'(oy_sel * ser_ff.c);
         k1_cx_ff     <= ser_ff.side.cx;
         k1_cy_ff     <= ser_ff.side.cy;
         k1_u_ff      <= sel_x ? tex_r_ff : tex_l_ff;
         k1_v_ff      <= sel_y ? tex_b_ff : tex_t_ff;
         k1_mode_ff   <= ser_ff.side.mode;
         k1_corner_ff <= ser_cnt_ff;

         k2_px_ff     <= 35'(rxr) + 35'(k1_cx_ff);
         k2_py_ff     <= 35'(ryr) + 35'(k1_cy_ff);
         k2_u_ff      <= k1_u_ff;
         k2_v_ff      <= k1_v_ff;
         k2_mode_ff   <= k1_mode_ff;
         k2_corner_ff <= k1_corner_ff;

         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         tex_u_ff     <= k2_u_ff;
         tex_v_ff     <= k2_v_ff;
         mode_ff      <= k2_mode_ff;
         corner_ff    <= k2_corner_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {tex_v_ff, tex_u_ff, pos_y_ff, pos_x_ff};
   assign rsp_tuser  = {mode_ff, corner_ff};
   assign rsp_tlast  = (corner_ff == sqv_pkg::CORNER_LAST);

endmodule
`default_nettype wire

FILE: hdl/sqv_cordic.sv
`default_nettype none
module sqv_cordic #(
   parameter int ITERATIONS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic signed [32:0] in_z,
   input  wire sqv_pkg::side_type  in_side,
   output logic                    out_valid,
   output logic signed [32:0]      out_x,
   output logic signed [32:0]      out_y,
   output sqv_pkg::side_type       out_side
);

   logic               valid_ff [ITERATIONS];
   logic signed [32:0] x_ff     [ITERATIONS];
   logic signed [32:0] y_ff     [ITERATIONS];
   logic signed [32:0] z_ff     [ITERATIONS];
   sqv_pkg::side_type  side_ff  [ITERATIONS];

   genvar i;
   for (i = 0; i < ITERATIONS; i++) begin : g_stage
      logic               v_prev;
      logic signed [32:0] x_prev, y_prev, z_prev;
      sqv_pkg::side_type  s_prev;
      logic signed [32:0] dx, dy, angle, x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign v_prev = in_valid;
         assign x_prev = sqv_pkg::CORDIC_GAIN;
         assign y_prev = 33'sd0;
         assign z_prev = in_z;
         assign s_prev = in_side;
      end else begin : g_next
         assign v_prev = valid_ff[i-1];
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
         assign s_prev = side_ff[i-1];
      end

      always_comb begin
         dx    = y_prev >>> i;
         dy    = x_prev >>> i;
         angle = sqv_pkg::atan_q30(5'(i));
         if (z_prev >= 33'sd0) begin
            x_in = x_prev - dx;
            y_in = y_prev + dy;
            z_in = z_prev - angle;
         end else begin
            x_in = x_prev + dx;
            y_in = y_prev - dy;
            z_in = z_prev + angle;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= s_prev;
         end
      end
   end

   assign out_valid = valid_ff[ITERATIONS-1];
   assign out_x     = x_ff[ITERATIONS-1];
   assign out_y     = y_ff[ITERATIONS-1];
   assign out_side  = side_ff[ITERATIONS-1];

endmodule
`default_nettype wire

FILE: hdl/sqv_checker.sv
`default_nettype none
`include "sprite_quad_vertex_gen_macros.svh"
module sqv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic [9:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   `SQV_ASSERT(a_valid_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp word dropped")
   `SQV_ASSERT(a_data_hold, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp word changed")
   `SQV_ASSERT(a_last_corner, rsp_tvalid |-> (rsp_tlast == (rsp_tuser[1:0] == sqv_pkg::CORNER_LAST)), "tlast off")
   `SQV_ASSERT_ALWAYS(a_reset_idle, !reset && $past(reset) |-> !rsp_tvalid, "rsp valid after reset")

endmodule

bind sprite_quad_vertex_gen sqv_checker u_sqv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
